/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; take in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in this cycle, consequent in the next
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent and consequent in the same cycle
`define ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/orbk_pkg.sv */
// Shared types, constants, saturating helpers and the microprogram ROM
// of the RK4/J2 orbit propagator. Depends on nothing.
package orbk_pkg;

    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE_Q = 64'h0000_1000_0000_0000;
    localparam logic [63:0] FIVE_Q = 64'h0000_5000_0000_0000;
    localparam logic [63:0] K_J2 = 64'd28568663401;
    localparam logic [63:0] SIX_I = 64'd6;
    localparam logic [63:0] RECIP6 = 64'hAAAA_AAAA_AAAA_AAAB;
    localparam logic [127:0] HALF_LSB = 128'h0000_0000_0000_0000_0000_0800_0000_0000;
    localparam logic [62:0] MU_RST = 63'd7012253097866077143;
    localparam logic [62:0] AE_RST = 63'd112205355128587289;
    localparam logic [15:0] STEP_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [2:0] REG_POS_X = 3'd0;
    localparam logic [2:0] REG_POS_Y = 3'd1;
    localparam logic [2:0] REG_POS_Z = 3'd2;
    localparam logic [2:0] REG_VEL_X = 3'd3;
    localparam logic [2:0] REG_VEL_Y = 3'd4;
    localparam logic [2:0] REG_VEL_Z = 3'd5;
    localparam logic [2:0] REG_MU    = 3'd6;
    localparam logic [2:0] REG_AE    = 3'd7;

    typedef logic [5:0] addr_t;
    typedef logic [5:0] upc_t;

    // operand space: fixed registers below 32, scratch memory from 32 up
    localparam addr_t A_INIT0  = 6'd0;
    localparam addr_t A_MU     = 6'd6;
    localparam addr_t A_AE     = 6'd7;
    localparam addr_t A_POSX   = 6'd8;
    localparam addr_t A_POSY   = 6'd9;
    localparam addr_t A_POSZ   = 6'd10;
    localparam addr_t A_VELX   = 6'd11;
    localparam addr_t A_VELY   = 6'd12;
    localparam addr_t A_VELZ   = 6'd13;
    localparam addr_t A_K      = 6'd14;
    localparam addr_t A_ONE    = 6'd15;
    localparam addr_t A_FIVE   = 6'd16;
    localparam addr_t A_ZERO   = 6'd17;
    localparam addr_t A_SIX    = 6'd18;
    localparam addr_t A_POS_AX = 6'd19;
    localparam addr_t A_VEL_AX = 6'd20;
    localparam addr_t A_NP_AX  = 6'd21;
    localparam addr_t A_NV_AX  = 6'd22;
    localparam addr_t A_NP0    = 6'd32;
    localparam addr_t A_NV0    = 6'd35;
    localparam addr_t A_TR     = 6'd38;
    localparam addr_t A_FC     = 6'd39;
    localparam addr_t A_FW     = 6'd40;
    localparam addr_t A_FQ     = 6'd41;
    localparam addr_t A_T1     = 6'd42;
    localparam addr_t A_T2     = 6'd43;
    localparam addr_t A_T3     = 6'd44;
    localparam addr_t A_T4     = 6'd45;
    localparam addr_t A_H      = 6'd46;
    localparam addr_t A_Q0     = 6'd47;
    localparam addr_t A_Q1     = 6'd48;
    localparam addr_t A_Q2     = 6'd49;
    localparam addr_t A_Q3     = 6'd50;
    localparam addr_t A_K1     = 6'd51;
    localparam addr_t A_K2     = 6'd52;
    localparam addr_t A_K3     = 6'd53;
    localparam addr_t A_T      = 6'd54;
    localparam addr_t A_U      = 6'd55;

    localparam upc_t PC_AXIS  = 6'd4;
    localparam upc_t PC_FORCE = 6'd49;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_HALF, OP_MUL, OP_DIV, OP_IDIV, OP_SQ0, OP_SQA,
        OP_SQRT, OP_CALL, OP_RET, OP_LOOP, OP_END
    } op_t;

    typedef struct packed {
        op_t   op;
        addr_t dst;
        addr_t sa;
        addr_t sb;
        upc_t  tgt;
    } uword_t;

    typedef struct packed {
        logic       rd_en;
        logic       wr_en;
        logic       load_init;
        addr_t      dst;
        addr_t      sa;
        addr_t      sb;
        logic [1:0] axis;
    } dp_ctrl_t;

    typedef enum logic [2:0] {
        SQ_IDLE, SQ_FETCH, SQ_START, SQ_WAIT, SQ_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        AR_IDLE, AR_MUL, AR_MFIN, AR_DIV, AR_DFIN, AR_SQRT, AR_RFIN, AR_DONE
    } ar_state_t;

    function automatic logic [63:0] qsat(logic [63:0] m, logic over, logic neg);
        logic [63:0] r;
        if (neg) begin
            if (over || (m > SMIN)) r = SMIN;
            else r = 64'd0 - m;
        end
        else begin
            if (over || m[63]) r = SMAX;
            else r = m;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] ssub(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? SMIN : SMAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] half(logic [63:0] a);
        logic [63:0] t;
        t = a + {63'd0, a[63]};
        return {t[63], t[63:1]};
    endfunction

    function automatic uword_t uw(op_t o, addr_t d, addr_t a, addr_t b, upc_t t);
        uword_t w;
        w.op = o;
        w.dst = d;
        w.sa = a;
        w.sb = b;
        w.tgt = t;
        return w;
    endfunction

    function automatic uword_t ucode(upc_t pc);
        uword_t w;
        case (pc)
            6'd0:  w = uw(OP_SQ0,  A_ZERO,  A_POSX,   A_POSX,   6'd0);
            6'd1:  w = uw(OP_SQA,  A_ZERO,  A_POSY,   A_POSY,   6'd0);
            6'd2:  w = uw(OP_SQA,  A_ZERO,  A_POSZ,   A_POSZ,   6'd0);
            6'd3:  w = uw(OP_SQRT, A_TR,    A_ZERO,   A_ZERO,   6'd0);
            6'd4:  w = uw(OP_ADD,  A_FC,    A_POS_AX, A_ZERO,   6'd0);
            6'd5:  w = uw(OP_ADD,  A_FW,    A_POSZ,   A_ZERO,   6'd0);
            6'd6:  w = uw(OP_CALL, A_ZERO,  A_ZERO,   A_ZERO,   PC_FORCE);
            6'd7:  w = uw(OP_ADD,  A_Q0,    A_FQ,     A_ZERO,   6'd0);
            6'd8:  w = uw(OP_HALF, A_H,     A_Q0,     A_ZERO,   6'd0);
            6'd9:  w = uw(OP_ADD,  A_K1,    A_VEL_AX, A_H,      6'd0);
            6'd10: w = uw(OP_HALF, A_H,     A_VEL_AX, A_ZERO,   6'd0);
            6'd11: w = uw(OP_ADD,  A_FC,    A_POS_AX, A_H,      6'd0);
            6'd12: w = uw(OP_ADD,  A_FW,    A_POSZ,   A_H,      6'd0);
            6'd13: w = uw(OP_CALL, A_ZERO,  A_ZERO,   A_ZERO,   PC_FORCE);
            6'd14: w = uw(OP_ADD,  A_Q1,    A_FQ,     A_ZERO,   6'd0);
            6'd15: w = uw(OP_HALF, A_H,     A_Q1,     A_ZERO,   6'd0);
            6'd16: w = uw(OP_ADD,  A_K2,    A_VEL_AX, A_H,      6'd0);
            6'd17: w = uw(OP_HALF, A_H,     A_K1,     A_ZERO,   6'd0);
            6'd18: w = uw(OP_ADD,  A_FC,    A_POS_AX, A_H,      6'd0);
            6'd19: w = uw(OP_ADD,  A_FW,    A_POSZ,   A_H,      6'd0);
            6'd20: w = uw(OP_CALL, A_ZERO,  A_ZERO,   A_ZERO,   PC_FORCE);
            6'd21: w = uw(OP_ADD,  A_Q2,    A_FQ,     A_ZERO,   6'd0);
            6'd22: w = uw(OP_ADD,  A_K3,    A_VEL_AX, A_Q2,     6'd0);
            6'd23: w = uw(OP_ADD,  A_FC,    A_POS_AX, A_K2,     6'd0);
            6'd24: w = uw(OP_ADD,  A_FW,    A_POSZ,   A_K2,     6'd0);
            6'd25: w = uw(OP_CALL, A_ZERO,  A_ZERO,   A_ZERO,   PC_FORCE);
            6'd26: w = uw(OP_ADD,  A_Q3,    A_FQ,     A_ZERO,   6'd0);
            6'd27: w = uw(OP_ADD,  A_T,     A_K1,     A_K1,     6'd0);
            6'd28: w = uw(OP_ADD,  A_T,     A_VEL_AX, A_T,      6'd0);
            6'd29: w = uw(OP_ADD,  A_U,     A_K2,     A_K2,     6'd0);
            6'd30: w = uw(OP_ADD,  A_T,     A_T,      A_U,      6'd0);
            6'd31: w = uw(OP_ADD,  A_T,     A_T,      A_K3,     6'd0);
            6'd32: w = uw(OP_IDIV, A_T,     A_T,      A_SIX,    6'd0);
            6'd33: w = uw(OP_ADD,  A_NP_AX, A_POS_AX, A_T,      6'd0);
            6'd34: w = uw(OP_ADD,  A_T,     A_Q1,     A_Q1,     6'd0);
            6'd35: w = uw(OP_ADD,  A_T,     A_Q0,     A_T,      6'd0);
            6'd36: w = uw(OP_ADD,  A_U,     A_Q2,     A_Q2,     6'd0);
            6'd37: w = uw(OP_ADD,  A_T,     A_T,      A_U,      6'd0);
            6'd38: w = uw(OP_ADD,  A_T,     A_T,      A_Q3,     6'd0);
            6'd39: w = uw(OP_IDIV, A_T,     A_T,      A_SIX,    6'd0);
            6'd40: w = uw(OP_ADD,  A_NV_AX, A_VEL_AX, A_T,      6'd0);
            6'd41: w = uw(OP_LOOP, A_ZERO,  A_ZERO,   A_ZERO,   PC_AXIS);
            6'd42: w = uw(OP_ADD,  A_POSX,  A_NP0,    A_ZERO,   6'd0);
            6'd43: w = uw(OP_ADD,  A_POSY,  A_NP0 + 6'd1, A_ZERO, 6'd0);
            6'd44: w = uw(OP_ADD,  A_POSZ,  A_NP0 + 6'd2, A_ZERO, 6'd0);
            6'd45: w = uw(OP_ADD,  A_VELX,  A_NV0,    A_ZERO,   6'd0);
            6'd46: w = uw(OP_ADD,  A_VELY,  A_NV0 + 6'd1, A_ZERO, 6'd0);
            6'd47: w = uw(OP_ADD,  A_VELZ,  A_NV0 + 6'd2, A_ZERO, 6'd0);
            6'd48: w = uw(OP_END,  A_ZERO,  A_ZERO,   A_ZERO,   6'd0);
            6'd49: w = uw(OP_DIV,  A_T1,    A_MU,     A_TR,     6'd0);
            6'd50: w = uw(OP_DIV,  A_T1,    A_T1,     A_TR,     6'd0);
            6'd51: w = uw(OP_DIV,  A_T2,    A_FC,     A_TR,     6'd0);
            6'd52: w = uw(OP_DIV,  A_T3,    A_FW,     A_TR,     6'd0);
            6'd53: w = uw(OP_DIV,  A_T4,    A_AE,     A_TR,     6'd0);
            6'd54: w = uw(OP_MUL,  A_T3,    A_T3,     A_T3,     6'd0);
            6'd55: w = uw(OP_MUL,  A_T3,    A_T3,     A_FIVE,   6'd0);
            6'd56: w = uw(OP_SUB,  A_T3,    A_T3,     A_ONE,    6'd0);
            6'd57: w = uw(OP_MUL,  A_T4,    A_T4,     A_T4,     6'd0);
            6'd58: w = uw(OP_MUL,  A_T4,    A_K,      A_T4,     6'd0);
            6'd59: w = uw(OP_MUL,  A_T4,    A_T4,     A_T3,     6'd0);
            6'd60: w = uw(OP_SUB,  A_T4,    A_T4,     A_ONE,    6'd0);
            6'd61: w = uw(OP_MUL,  A_T1,    A_T1,     A_T2,     6'd0);
            6'd62: w = uw(OP_MUL,  A_FQ,    A_T1,     A_T4,     6'd0);
            6'd63: w = uw(OP_RET,  A_ZERO,  A_ZERO,   A_ZERO,   6'd0);
            default: w = uw(OP_END, A_ZERO, A_ZERO,   A_ZERO,   6'd0);
        endcase
        return w;
    endfunction

endpackage

/* hdl/orbit_rk4_j2_propagator_unit.sv */
// One-second RK4 orbit step with J2 term on Q20.44 state; each transfer in gives
// one transfer out. A restart transfer loads the configured initial state as the
// result; an advance runs the bit-serial divider (one quotient bit a cycle, 60
// divisions by r per step) that a microcoded sequencer drives with the multiplier
// and square-root unit. The input stalls until the result is loaded for output.
// Depends on orbk_pkg, orbk_seq, orbk_dpath, orbk_arith.
module orbit_rk4_j2_propagator_unit
    import orbk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               restart,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] pos_x,
    output logic signed [63:0] pos_y,
    output logic signed [63:0] pos_z,
    output logic signed [63:0] vel_x,
    output logic signed [63:0] vel_y,
    output logic signed [63:0] vel_z,
    output logic [15:0]        step_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    dp_ctrl_t         ctrl;
    logic             busy, go, out_free, out_load;
    logic             ar_start, ar_done;
    op_t              ar_op;
    logic [63:0]      op_a, op_b, ar_res;
    logic [2:0][63:0] pos_q, vel_q;
    logic [15:0]      step_reg;
    logic             out_valid_reg;
    logic [63:0]      px_reg, py_reg, pz_reg, vx_reg, vy_reg, vz_reg;
    logic [15:0]      si_reg;

    assign go        = in_valid && !in_stall;
    assign in_stall  = busy;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    orbk_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .go_restart (restart),
        .out_free   (out_free),
        .ar_done    (ar_done),
        .ctrl       (ctrl),
        .ar_start   (ar_start),
        .ar_op      (ar_op),
        .busy       (busy),
        .out_load   (out_load)
    );

    orbk_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .wdata     (ar_res),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .op_a      (op_a),
        .op_b      (op_b),
        .pos_q     (pos_q),
        .vel_q     (vel_q)
    );

    orbk_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ar_start),
        .op     (ar_op),
        .a      (op_a),
        .b      (op_b),
        .done   (ar_done),
        .result (ar_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                if (restart) step_reg <= '0;
                else if (step_reg != STEP_MAX) step_reg <= step_reg + 16'd1;
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            px_reg <= pos_q[0];
            py_reg <= pos_q[1];
            pz_reg <= pos_q[2];
            vx_reg <= vel_q[0];
            vy_reg <= vel_q[1];
            vz_reg <= vel_q[2];
            si_reg <= step_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pos_x      = px_reg;
    assign pos_y      = py_reg;
    assign pos_z      = pz_reg;
    assign vel_x      = vx_reg;
    assign vel_y      = vy_reg;
    assign vel_z      = vz_reg;
    assign step_index = si_reg;

endmodule

/* hdl/orbk_arith.sv */
// Shared arithmetic unit: saturating add/sub/halve, four-pass Q20.44 multiply
// (also the divide by six, as a reciprocal product), bit-serial divide and
// square root. Depends on orbk_pkg.
module orbk_arith
    import orbk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  op_t         op,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] result
);

    ar_state_t    st_reg, st_next;
    op_t          op_reg, op_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [63:0]  ma_reg, ma_next;
    logic [63:0]  mb_reg, mb_next;
    logic         neg_reg, neg_next;
    logic [127:0] acc_reg, acc_next;
    logic [127:0] sq_reg, sq_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   ppsh_reg, ppsh_next;
    logic [127:0] dvd_reg, dvd_next;
    logic [63:0]  rem_reg, rem_next;
    logic [63:0]  q_reg, q_next;
    logic         over_reg, over_next;
    logic [67:0]  srem_reg, srem_next;
    logic [63:0]  rt_reg, rt_next;
    logic [63:0]  res_reg, res_next;

    logic [127:0] rnd;
    logic [64:0]  rsh;
    logic         dge;
    logic [67:0]  ssh;
    logic [67:0]  trial;
    logic         sge;
    logic [31:0]  ha, hb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= AR_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        cnt_reg  <= cnt_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        sq_reg   <= sq_next;
        pp_reg   <= pp_next;
        ppsh_reg <= ppsh_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        over_reg <= over_next;
        srem_reg <= srem_next;
        rt_reg   <= rt_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        sq_next   = sq_reg;
        pp_next   = pp_reg;
        ppsh_next = ppsh_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        over_next = over_reg;
        srem_next = srem_reg;
        rt_next   = rt_reg;
        res_next  = res_reg;

        rnd   = acc_reg + HALF_LSB;
        rsh   = {rem_reg, dvd_reg[127]};
        dge   = rsh >= {1'b0, mb_reg};
        ssh   = {srem_reg[65:0], dvd_reg[127:126]};
        trial = {2'b00, rt_reg, 2'b01};
        sge   = ssh >= trial;
        ha    = cnt_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        hb    = cnt_reg[0] ? mb_reg[63:32] : mb_reg[31:0];

        case (st_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    ma_next  = mag(a);
                    mb_next  = mag(b);
                    neg_next = a[63] ^ b[63];
                    cnt_next = 7'd0;
                    case (op)
                        OP_ADD:
                        begin
                            res_next = sadd(a, b);
                            st_next  = AR_DONE;
                        end
                        OP_SUB:
                        begin
                            res_next = ssub(a, b);
                            st_next  = AR_DONE;
                        end
                        OP_HALF:
                        begin
                            res_next = half(a);
                            st_next  = AR_DONE;
                        end
                        OP_MUL, OP_SQ0, OP_SQA:
                        begin
                            acc_next = 128'd0;
                            st_next  = AR_MUL;
                        end
                        OP_IDIV:
                        begin
                            mb_next  = RECIP6;
                            acc_next = 128'd0;
                            st_next  = AR_MUL;
                        end
                        OP_DIV:
                        begin
                            if (b == 64'd0)
                            begin
                                res_next = (a == 64'd0) ? 64'd0 : (a[63] ? SMIN : SMAX);
                                st_next  = AR_DONE;
                            end
                            else
                            begin
                                dvd_next  = {20'd0, mag(a), 44'd0};
                                rem_next  = 64'd0;
                                q_next    = 64'd0;
                                over_next = 1'b0;
                                cnt_next  = 7'd127;
                                st_next   = AR_DIV;
                            end
                        end
                        OP_SQRT:
                        begin
                            dvd_next  = sq_reg;
                            srem_next = 68'd0;
                            rt_next   = 64'd0;
                            cnt_next  = 7'd63;
                            st_next   = AR_SQRT;
                        end
                        default:
                        begin
                            res_next = 64'd0;
                            st_next  = AR_DONE;
                        end
                    endcase
                end
            end
            AR_MUL:
            begin
                if (cnt_reg != 7'd4)
                begin
                    pp_next   = {32'd0, ha} * {32'd0, hb};
                    ppsh_next = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                end
                if (cnt_reg != 7'd0)
                begin
                    acc_next = acc_reg + ({64'd0, pp_reg} << {ppsh_reg, 5'd0});
                end
                if (cnt_reg == 7'd4)
                begin
                    st_next = AR_MFIN;
                end
                cnt_next = cnt_reg + 7'd1;
            end
            AR_MFIN:
            begin
                case (op_reg)
                    OP_SQ0:  sq_next = acc_reg;
                    OP_SQA:  sq_next = sq_reg + acc_reg;
                    OP_IDIV: res_next = qsat({2'b00, acc_reg[127:66]}, 1'b0, neg_reg);
                    default: res_next = qsat(rnd[107:44], |rnd[127:108], neg_reg);
                endcase
                st_next = AR_DONE;
            end
            AR_DIV:
            begin
                rem_next  = dge ? (rsh[63:0] - mb_reg) : rsh[63:0];
                dvd_next  = {dvd_reg[126:0], 1'b0};
                q_next    = {q_reg[62:0], dge};
                over_next = over_reg | (dge & cnt_reg[6]);
                if (cnt_reg == 7'd0) st_next = AR_DFIN;
                else cnt_next = cnt_reg - 7'd1;
            end
            AR_DFIN:
            begin
                res_next = qsat(q_reg, over_reg, neg_reg);
                st_next  = AR_DONE;
            end
            AR_SQRT:
            begin
                srem_next = sge ? (ssh - trial) : ssh;
                rt_next   = {rt_reg[62:0], sge};
                dvd_next  = {dvd_reg[125:0], 2'b00};
                if (cnt_reg == 7'd0) st_next = AR_RFIN;
                else cnt_next = cnt_reg - 7'd1;
            end
            AR_RFIN:
            begin
                res_next = rt_reg[63] ? SMAX : rt_reg;
                st_next  = AR_DONE;
            end
            AR_DONE:
            begin
                st_next = AR_IDLE;
            end
            default:
            begin
                st_next = AR_IDLE;
            end
        endcase
    end

    assign done   = (st_reg == AR_DONE);
    assign result = res_reg;

endmodule

/* hdl/orbk_dpath.sv */
// Operand store: configuration registers, held state vector, constants and
// the scratch memory, with registered operand reads. Depends on orbk_pkg.
module orbk_dpath
    import orbk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_ctrl_t         ctrl,
    input  logic [63:0]      wdata,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_idx,
    input  logic [63:0]      cfg_wdata,
    output logic [63:0]      op_a,
    output logic [63:0]      op_b,
    output logic [2:0][63:0] pos_q,
    output logic [2:0][63:0] vel_q
);

    logic [5:0][63:0] init_reg;
    logic [62:0]      mu_reg;
    logic [62:0]      ae_reg;
    logic [2:0][63:0] pos_reg;
    logic [2:0][63:0] vel_reg;
    logic [63:0]      mem [32];
    logic [63:0]      rd_a_reg, rd_b_reg, fix_a_reg, fix_b_reg;
    logic             sel_a_reg, sel_b_reg;
    addr_t            ra, rb, wa, sidx;

    function automatic addr_t resolve(addr_t ad, logic [1:0] ax);
        addr_t r;
        case (ad)
            A_POS_AX: r = A_POSX + {4'd0, ax};
            A_VEL_AX: r = A_VELX + {4'd0, ax};
            A_NP_AX:  r = A_NP0 + {4'd0, ax};
            A_NV_AX:  r = A_NV0 + {4'd0, ax};
            default:  r = ad;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] fixed_rd(addr_t ad, logic [5:0][63:0] ini,
                                             logic [62:0] mu, logic [62:0] ae,
                                             logic [2:0][63:0] p,
                                             logic [2:0][63:0] v);
        logic [63:0] r;
        case (ad)
            A_INIT0, A_INIT0 + 6'd1, A_INIT0 + 6'd2,
            A_INIT0 + 6'd3, A_INIT0 + 6'd4, A_INIT0 + 6'd5: r = ini[ad[2:0]];
            A_MU:   r = {1'b0, mu};
            A_AE:   r = {1'b0, ae};
            A_POSX: r = p[0];
            A_POSY: r = p[1];
            A_POSZ: r = p[2];
            A_VELX: r = v[0];
            A_VELY: r = v[1];
            A_VELZ: r = v[2];
            A_K:    r = K_J2;
            A_ONE:  r = ONE_Q;
            A_FIVE: r = FIVE_Q;
            A_SIX:  r = SIX_I;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        ra   = resolve(ctrl.sa, ctrl.axis);
        rb   = resolve(ctrl.sb, ctrl.axis);
        wa   = resolve(ctrl.dst, ctrl.axis);
        sidx = wa - A_POSX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
            mu_reg   <= MU_RST;
            ae_reg   <= AE_RST;
            pos_reg  <= '0;
            vel_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_MU:  mu_reg <= cfg_wdata[62:0];
                    REG_AE:  ae_reg <= cfg_wdata[62:0];
                    default: init_reg[cfg_idx] <= cfg_wdata;
                endcase
            end
            if (ctrl.load_init)
            begin
                pos_reg <= {init_reg[2], init_reg[1], init_reg[0]};
                vel_reg <= {init_reg[5], init_reg[4], init_reg[3]};
            end
            else if (ctrl.wr_en && !wa[5] && wa >= A_POSX && wa <= A_VELZ)
            begin
                if (sidx < 6'd3) pos_reg[sidx[1:0]] <= wdata;
                else vel_reg[sidx[1:0] - 2'd3] <= wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en && wa[5])
        begin
            mem[wa[4:0]] <= wdata;
        end
        if (ctrl.rd_en)
        begin
            rd_a_reg  <= mem[ra[4:0]];
            rd_b_reg  <= mem[rb[4:0]];
            sel_a_reg <= ra[5];
            sel_b_reg <= rb[5];
            fix_a_reg <= fixed_rd(ra, init_reg, mu_reg, ae_reg, pos_reg, vel_reg);
            fix_b_reg <= fixed_rd(rb, init_reg, mu_reg, ae_reg, pos_reg, vel_reg);
        end
    end

    assign op_a  = sel_a_reg ? rd_a_reg : fix_a_reg;
    assign op_b  = sel_b_reg ? rd_b_reg : fix_b_reg;
    assign pos_q = pos_reg;
    assign vel_q = vel_reg;

endmodule

/* hdl/orbk_seq.sv */
// Microcode sequencer: program counter, call/return and axis loop over the
// ROM in orbk_pkg. Depends on orbk_pkg.
module orbk_seq
    import orbk_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     go,
    input  logic     go_restart,
    input  logic     out_free,
    input  logic     ar_done,
    output dp_ctrl_t ctrl,
    output logic     ar_start,
    output op_t      ar_op,
    output logic     busy,
    output logic     out_load
);

    seq_state_t st_reg, st_next;
    upc_t       pc_reg, pc_next;
    upc_t       ret_reg, ret_next;
    logic [1:0] axis_reg, axis_next;
    uword_t     w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= SQ_IDLE;
            pc_reg   <= '0;
            ret_reg  <= '0;
            axis_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            pc_reg   <= pc_next;
            ret_reg  <= ret_next;
            axis_reg <= axis_next;
        end
    end

    always_comb
    begin
        w              = ucode(pc_reg);
        st_next        = st_reg;
        pc_next        = pc_reg;
        ret_next       = ret_reg;
        axis_next      = axis_reg;
        ctrl.rd_en     = 1'b0;
        ctrl.wr_en     = 1'b0;
        ctrl.load_init = 1'b0;
        ctrl.dst       = w.dst;
        ctrl.sa        = w.sa;
        ctrl.sb        = w.sb;
        ctrl.axis      = axis_reg;
        ar_start       = 1'b0;
        out_load       = 1'b0;
        case (st_reg)
            SQ_IDLE:
            begin
                if (go)
                begin
                    if (go_restart)
                    begin
                        ctrl.load_init = 1'b1;
                        st_next        = SQ_DONE;
                    end
                    else
                    begin
                        pc_next   = '0;
                        axis_next = '0;
                        st_next   = SQ_FETCH;
                    end
                end
            end
            SQ_FETCH:
            begin
                case (w.op)
                    OP_CALL:
                    begin
                        ret_next = pc_reg + 6'd1;
                        pc_next  = w.tgt;
                    end
                    OP_RET:
                    begin
                        pc_next = ret_reg;
                    end
                    OP_LOOP:
                    begin
                        if (axis_reg != 2'd2)
                        begin
                            axis_next = axis_reg + 2'd1;
                            pc_next   = w.tgt;
                        end
                        else
                        begin
                            pc_next = pc_reg + 6'd1;
                        end
                    end
                    OP_END:
                    begin
                        st_next = SQ_DONE;
                    end
                    default:
                    begin
                        ctrl.rd_en = 1'b1;
                        st_next    = SQ_START;
                    end
                endcase
            end
            SQ_START:
            begin
                ar_start = 1'b1;
                st_next  = SQ_WAIT;
            end
            SQ_WAIT:
            begin
                if (ar_done)
                begin
                    ctrl.wr_en = (w.op == OP_ADD) || (w.op == OP_SUB) ||
                                 (w.op == OP_HALF) || (w.op == OP_MUL) ||
                                 (w.op == OP_DIV) || (w.op == OP_IDIV) ||
                                 (w.op == OP_SQRT);
                    pc_next = pc_reg + 6'd1;
                    st_next = SQ_FETCH;
                end
            end
            SQ_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    st_next  = SQ_IDLE;
                end
            end
            default:
            begin
                st_next = SQ_IDLE;
            end
        endcase
    end

    assign ar_op = w.op;
    assign busy  = (st_reg != SQ_IDLE);

endmodule

/* hdl/orbk_checker.sv */
// Port-level checks on the propagator's transfers, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module orbk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] pos_x,
    input logic [63:0] vel_z,
    input logic [15:0] step_index
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(pos_x) && $stable(vel_z) && $stable(step_index))
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_SAME(a_out_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind orbit_rk4_j2_propagator_unit orbk_checker u_chk (.*);
